/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// clocked, reset-qualified implication checks shared by the svpc design
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on clk_i, disabled while rst_ni is low
`define SVPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("svpc: implication check failed");

// next-cycle implication on clk_i, disabled while rst_ni is low
`define SVPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error("svpc: next-cycle check failed");

`endif

/* design/svpc_pkg.sv */
// ---------------------------------------------------------------------------
// svpc_pkg
// shared types, constants and the sine table generator of the svpwm block
// ---------------------------------------------------------------------------
`default_nettype none

package svpc_pkg;

  // angle resolution and sine table size
  localparam int unsigned ANGLE_BITS   = 16;
  localparam int unsigned SINE_ENTRIES = 1024;
  localparam int unsigned KW           = $clog2(SINE_ENTRIES + 1);

  // q1.15 one
  localparam logic [15:0] Q15_ONE = 16'd32768;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic CFG_ENERGY_LIMIT = 1'b0;
  localparam logic CFG_TIMER_PERIOD = 1'b1;

  // sixty-degree sectors
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } svpc_sector_e;

  // classified request handed from front to back
  typedef struct packed {
    svpc_sector_e      sector;
    logic [KW-1:0]     idx;
    logic [15:0]       mag;
  } svpc_item_t;

  // pi in q60 and the per-entry angle step
  localparam logic [63:0] PI_Q60   = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] SINE_DIV = 64'(3 * SINE_ENTRIES);
  localparam logic [63:0] SINE_Q   = PI_Q60 / SINE_DIV;
  localparam logic [63:0] SINE_R   = PI_Q60 % SINE_DIV;

  // (a * b) >> 60 with 64-bit wraparound
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah;
    logic [63:0] al;
    logic [63:0] bh;
    logic [63:0] bl;
    logic [63:0] lo;
    logic [63:0] mid;
    logic [63:0] acc;
    ah  = a >> 32;
    al  = a & 64'h0000_0000_FFFF_FFFF;
    bh  = b >> 32;
    bl  = b & 64'h0000_0000_FFFF_FFFF;
    lo  = al * bl;
    mid = ah * bl + al * bh;
    acc = (lo >> 32) + (mid & 64'h0000_0000_FFFF_FFFF);
    return ((ah * bh) << 4) + (mid >> 28)
         + ((acc >> 28) - ((mid & 64'h0000_0000_FFFF_FFFF) >> 28));
  endfunction

  // rounded q1.15 sine of a q60 angle, taylor series to the 21st power
  function automatic logic [15:0] sine_q15(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    // term n divides by (2n)(2n+1), signs alternate starting with minus
    term = mul_q60(term, x2) / 64'd6;
    sum  = sum - term;
    term = mul_q60(term, x2) / 64'd20;
    sum  = sum + term;
    term = mul_q60(term, x2) / 64'd42;
    sum  = sum - term;
    term = mul_q60(term, x2) / 64'd72;
    sum  = sum + term;
    term = mul_q60(term, x2) / 64'd110;
    sum  = sum - term;
    term = mul_q60(term, x2) / 64'd156;
    sum  = sum + term;
    term = mul_q60(term, x2) / 64'd210;
    sum  = sum - term;
    term = mul_q60(term, x2) / 64'd272;
    sum  = sum + term;
    term = mul_q60(term, x2) / 64'd342;
    sum  = sum - term;
    term = mul_q60(term, x2) / 64'd420;
    sum  = sum + term;
    return 16'((sum + (64'd1 << 44)) >> 45);
  endfunction

  // table entry k covers k * 60deg / SINE_ENTRIES
  function automatic logic [15:0] sine_entry(input int unsigned k);
    logic [63:0] kk;
    kk = 64'(k);
    return sine_q15(SINE_Q * kk + (SINE_R * kk) / SINE_DIV);
  endfunction

endpackage

`default_nettype wire

/* design/svpc_front.sv */
// ---------------------------------------------------------------------------
// svpc_front
// takes a request, splits the angle into sector and table index, limits
// the magnitude, and holds the result until the queue takes it
// ---------------------------------------------------------------------------
`default_nettype none

module svpc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [15:0]            vector_angle_i,
  input  logic [15:0]            vector_magnitude_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output svpc_pkg::svpc_item_t   item_o,
  output logic                   busy_o
);
  import svpc_pkg::*;

  localparam int unsigned PW = ANGLE_BITS + 3;
  localparam int unsigned FW = ANGLE_BITS + KW;

  logic                  valid_q, valid_d;
  logic                  accept;
  svpc_item_t            item_q, item_d;
  logic [ANGLE_BITS-1:0] angle;
  logic [PW-1:0]         pos;
  logic [ANGLE_BITS-1:0] frac;
  logic [FW-1:0]         scaled;

  // handshake
  assign busy_o = valid_q && q_full_i;
  assign accept = start_i && !busy_o;
  assign push_o = valid_q && !q_full_i;

  // sector and local angle: angle * 6, integer part is the sector
  always_comb begin
    angle  = ANGLE_BITS'(vector_angle_i);
    pos    = PW'(angle) * PW'(3'd6);
    frac   = pos[ANGLE_BITS-1:0];
    scaled = FW'(frac) * FW'(SINE_ENTRIES);
    item_d.sector = svpc_sector_e'(pos[ANGLE_BITS +: 3]);
    item_d.idx    = scaled[ANGLE_BITS +: KW];
    item_d.mag    = (vector_magnitude_i > Q15_ONE) ? Q15_ONE : vector_magnitude_i;
  end

  // holding register valid
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

/* design/svpc_queue.sv */
// ---------------------------------------------------------------------------
// svpc_queue
// short request queue between the front and the back
// ---------------------------------------------------------------------------
`default_nettype none

module svpc_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  svpc_pkg::svpc_item_t   item_i,
  input  logic                   pop_i,
  output logic                   full_o,
  output logic                   valid_o,
  output svpc_pkg::svpc_item_t   item_o
);
  import svpc_pkg::*;

  svpc_item_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rptr_q];

  // pointer wrap and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* design/svpc_back.sv */
// ---------------------------------------------------------------------------
// svpc_back
// sine lookup, vector times, per-phase duty select, scaling and clamping;
// five register stages, one request per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module svpc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  svpc_pkg::svpc_item_t   item_i,
  input  logic [15:0]            energy_limit_i,
  input  logic [15:0]            timer_period_i,
  output logic                   pop_o,
  output logic                   result_valid_o,
  output logic [15:0]            compare_u_o,
  output logic [15:0]            compare_v_o,
  output logic [15:0]            compare_w_o,
  output logic [2:0]             sector_index_o
);
  import svpc_pkg::*;

  localparam int unsigned DW = 34;
  localparam logic signed [DW-1:0] ONE_Q30 = DW'(64'd1 << 30);

  // sine table, built at elaboration
  logic [15:0] rom_w [SINE_ENTRIES + 1];

  genvar g;
  for (g = 0; g <= SINE_ENTRIES; g++) begin : g_rom
    assign rom_w[g] = sine_entry(g);
  end

  logic [4:0]    vld_q, vld_d;

  logic [15:0]   s1_sin1_q, s1_sin2_q, s1_mag_q;
  svpc_sector_e  s1_sec_q;

  logic [31:0]   s2_t1_q, s2_t2_q;
  svpc_sector_e  s2_sec_q;

  logic [31:0]   s3_du_q, s3_dv_q, s3_dw_q, s3_lp_q;
  logic [31:0]   s3_du_d, s3_dv_d, s3_dw_d, s3_lp_d;
  svpc_sector_e  s3_sec_q;

  logic [17:0]   s4_u_q, s4_v_q, s4_w_q;
  logic [63:0]   s4_pu, s4_pv, s4_pw;
  svpc_sector_e  s4_sec_q;

  logic [15:0]   out_u_q, out_v_q, out_w_q;
  logic [15:0]   out_u_d, out_v_d, out_w_d;
  logic [2:0]    out_sec_q;

  logic signed [DW-1:0] t1, t2, t0, full, only1, only2;
  logic signed [DW-1:0] du, dv, dw;
  logic [15:0]          lim;

  // the back never stalls, so it takes the queue head whenever there is one
  assign pop_o = valid_i;

  // stage valids
  assign vld_d = {vld_q[3:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: table lookup for both angles
  always_ff @(posedge clk_i) begin
    s1_sin1_q <= rom_w[KW'(SINE_ENTRIES) - item_i.idx];
    s1_sin2_q <= rom_w[item_i.idx];
    s1_mag_q  <= item_i.mag;
    s1_sec_q  <= item_i.sector;
  end

  // stage 2: t1 and t2 in q2.30
  always_ff @(posedge clk_i) begin
    s2_t1_q  <= 32'(s1_mag_q) * 32'(s1_sin1_q);
    s2_t2_q  <= 32'(s1_mag_q) * 32'(s1_sin2_q);
    s2_sec_q <= s1_sec_q;
  end

  // stage 3: doubled duties per sector, negative duty floors at zero
  always_comb begin
    t1    = DW'(s2_t1_q);
    t2    = DW'(s2_t2_q);
    t0    = ONE_Q30 - t1 - t2;
    full  = ONE_Q30 + t1 + t2;
    only1 = ONE_Q30 + t1 - t2;
    only2 = ONE_Q30 - t1 + t2;
    unique case (s2_sec_q)
      SEC_0: begin
        du = full;  dv = only2; dw = t0;
      end
      SEC_1: begin
        du = only1; dv = full;  dw = t0;
      end
      SEC_2: begin
        du = t0;    dv = full;  dw = only2;
      end
      SEC_3: begin
        du = t0;    dv = only1; dw = full;
      end
      SEC_4: begin
        du = only2; dv = t0;    dw = full;
      end
      default: begin
        du = full;  dv = t0;    dw = only1;
      end
    endcase
    s3_du_d = du[DW-1] ? '0 : du[31:0];
    s3_dv_d = dv[DW-1] ? '0 : dv[31:0];
    s3_dw_d = dw[DW-1] ? '0 : dw[31:0];
    // limit times (period + 1), at most 2^31
    lim     = (energy_limit_i > Q15_ONE) ? Q15_ONE : energy_limit_i;
    s3_lp_d = 32'(lim) * (32'(timer_period_i) + 32'd1);
  end

  always_ff @(posedge clk_i) begin
    s3_du_q  <= s3_du_d;
    s3_dv_q  <= s3_dv_d;
    s3_dw_q  <= s3_dw_d;
    s3_lp_q  <= s3_lp_d;
    s3_sec_q <= s2_sec_q;
  end

  // stage 4: scale each duty, keep the integer part
  assign s4_pu = 64'(s3_du_q) * 64'(s3_lp_q);
  assign s4_pv = 64'(s3_dv_q) * 64'(s3_lp_q);
  assign s4_pw = 64'(s3_dw_q) * 64'(s3_lp_q);

  always_ff @(posedge clk_i) begin
    s4_u_q   <= s4_pu[63:46];
    s4_v_q   <= s4_pv[63:46];
    s4_w_q   <= s4_pw[63:46];
    s4_sec_q <= s3_sec_q;
  end

  // stage 5: clamp to the period
  always_comb begin
    out_u_d = (s4_u_q >= 18'(timer_period_i)) ? timer_period_i : s4_u_q[15:0];
    out_v_d = (s4_v_q >= 18'(timer_period_i)) ? timer_period_i : s4_v_q[15:0];
    out_w_d = (s4_w_q >= 18'(timer_period_i)) ? timer_period_i : s4_w_q[15:0];
  end

  always_ff @(posedge clk_i) begin
    out_u_q   <= out_u_d;
    out_v_q   <= out_v_d;
    out_w_q   <= out_w_d;
    out_sec_q <= s4_sec_q;
  end

  assign result_valid_o = vld_q[4];
  assign compare_u_o    = out_u_q;
  assign compare_v_o    = out_v_q;
  assign compare_w_o    = out_w_q;
  assign sector_index_o = out_sec_q;

endmodule

`default_nettype wire

/* design/space_vector_pwm_compare.sv */
// ---------------------------------------------------------------------------
// space_vector_pwm_compare
// center-aligned space vector pwm: angle and magnitude in, three timer
// compare values and the sector out
// ---------------------------------------------------------------------------
//  port group   direction  handshake            payload
//  request      in         start_i / busy_o     vector_angle_i, vector_magnitude_i
//  result       out        result_valid_o       compare_u/v/w_o, sector_index_o
//  config       in         cfg_we_i             cfg_idx_i, cfg_wdata_i
//
//  one request per cycle while busy_o is low; a request passes one register for
//  each step, in order: front register, queue entry, sine table read, time
//  multiply, duty select, scale multiply, clamp.
//  the two multiply stages set the clock path.
//  rst_ni clears the pipeline valids and queue pointers and restores
//  energy_limit to 32768 and timer_period to 65535; no clearing pass.
//  busy_o rises only if the queue fills, which the back never lets happen,
//  since results leave on the strobe without a receiver stall.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module space_vector_pwm_compare (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] vector_angle_i,
  input  logic [15:0] vector_magnitude_i,
  output logic        result_valid_o,
  output logic [15:0] compare_u_o,
  output logic [15:0] compare_v_o,
  output logic [15:0] compare_w_o,
  output logic [2:0]  sector_index_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import svpc_pkg::*;

  localparam int unsigned PIPE_LATENCY = 7;

  logic [15:0] limit_q, limit_d;
  logic [15:0] period_q, period_d;

  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        pop;
  logic        item_accept;
  svpc_item_t  front_item;
  svpc_item_t  head_item;

  // configuration registers
  always_comb begin
    limit_d  = limit_q;
    period_d = period_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENERGY_LIMIT: limit_d  = cfg_wdata_i;
        CFG_TIMER_PERIOD: period_d = cfg_wdata_i;
        default:          limit_d  = limit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= Q15_ONE;
      period_q <= 16'hFFFF;
    end else begin
      limit_q  <= limit_d;
      period_q <= period_d;
    end
  end

  assign item_accept = start_i && !busy_o;

  // request intake and classification
  svpc_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .vector_angle_i     (vector_angle_i),
    .vector_magnitude_i (vector_magnitude_i),
    .q_full_i           (q_full),
    .push_o             (push),
    .item_o             (front_item),
    .busy_o             (busy_o)
  );

  // decoupling queue
  svpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  // compare value pipeline
  svpc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .item_i         (head_item),
    .energy_limit_i (limit_q),
    .timer_period_i (period_q),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .compare_u_o    (compare_u_o),
    .compare_v_o    (compare_v_o),
    .compare_w_o    (compare_w_o),
    .sector_index_o (sector_index_o)
  );

  // every accepted request comes out after the fixed latency
  `SVPC_ASSERT_NXT(a_req_to_result, item_accept, ##(PIPE_LATENCY - 1) result_valid_o)
  // no result without a request that caused it
  `SVPC_ASSERT_IMP(a_no_phantom, result_valid_o, $past(item_accept, PIPE_LATENCY))
  // sector stays in range on every result
  `SVPC_ASSERT_IMP(a_sector_range, result_valid_o, (sector_index_o <= 3'(SEC_5)))
  // queue never fills behind a non-stalling back
  `SVPC_ASSERT_IMP(a_never_busy, q_valid, !q_full)

endmodule

`default_nettype wire
